// File: sv/sgvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgvc_pkg: shared types and constants of the scatter-gather vector coalescer
// Request and result payloads, queue entry layout and descriptor codes.
// ----------------------------------------------------------------------------
package sgvc_pkg;

  localparam int ADDR_W   = 48;
  localparam int LEN_W    = 32;
  localparam int VCNT_W   = 11;
  localparam int VIDX_W   = 10;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 32;

  localparam logic [VCNT_W-1:0] VEC_HARD_MAX = VCNT_W'(1024);
  localparam logic [LEN_W-1:0]  BYTE_LIMIT_RST = LEN_W'(65536);
  localparam logic [LEN_W-1:0]  PASS_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_MEM  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FILE = 2'd1;

  localparam logic ITEM_VEC = 1'b0;
  localparam logic ITEM_SUM = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VECTORS = 1'd1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [KIND_W-1:0] buf_kind;
    logic [ADDR_W-1:0] buf_addr;
    logic [LEN_W-1:0]  buf_len;
    logic              last_mark;
    logic              chain_start;
    logic              chain_end;
    logic [LEN_W-1:0]  start_bytes;
  } desc_t;

  typedef struct packed {
    logic              item_kind;
    logic [VIDX_W-1:0] vec_index;
    logic [ADDR_W-1:0] vec_base;
    logic [LEN_W-1:0]  vec_len;
    logic [VCNT_W-1:0] vector_count;
    logic [LEN_W-1:0]  total_bytes;
    logic              saw_sync;
    logic              saw_last;
    logic              limit_hit;
    logic              vectors_full;
    logic [LEN_W-1:0]  taken_count;
    logic              run_last;
  } res_t;

  typedef struct packed {
    logic [VIDX_W-1:0] index;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
  } vec_t;

  typedef struct packed {
    logic [VCNT_W-1:0] count;
    logic [LEN_W-1:0]  total;
    logic              sync;
    logic              last;
    logic              limit;
    logic              full;
    logic [LEN_W-1:0]  taken;
  } sum_t;

  typedef struct packed {
    logic has_a;
    logic has_b;
    logic has_s;
    vec_t a;
    vec_t b;
    sum_t s;
  } entry_t;

endpackage

// File: sv/scatter_gather_vector_coalescer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatter_gather_vector_coalescer: builds a scatter-gather vector list
// Front classifier, entry queue and result emitter.
// ----------------------------------------------------------------------------
// Usage:
//   desc/desc_valid/desc_stall carries buffer descriptors; a request is taken
//   at a clock edge with desc_valid high and desc_stall low.
//   res/res_valid/res_stall carries results: closed vectors, then a summary
//   at chain end. run_last marks the final result of one descriptor.
//   cfg_we/cfg_index/cfg_data write byte_limit (index 0) and max_vectors
//   (index 1); write only while the block is idle.
// Timing:
//   The classifier takes one descriptor per cycle while desc_stall is low. The
//   first result of a descriptor passes through the queue and the output
//   register. The emitter sends one result per cycle while res_stall is low;
//   a four-entry queue absorbs the difference and raises desc_stall when full.
// Reset:
//   rst clears the job state, the queue and res_valid and loads
//   byte_limit 65536 and max_vectors 1024.
// Stall:
//   While res_stall is high the current result holds; the queue fills and
//   then desc_stall rises.
// ----------------------------------------------------------------------------
module scatter_gather_vector_coalescer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              desc_valid,
  output logic                              desc_stall,
  input  sgvc_pkg::desc_t                   desc,
  output logic                              res_valid,
  input  logic                              res_stall,
  output sgvc_pkg::res_t                    res,
  input  logic                              cfg_we,
  input  logic [sgvc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgvc_pkg::CFG_W-1:0]        cfg_data
);

  logic             accept;
  logic             push;
  sgvc_pkg::entry_t entry;
  sgvc_pkg::entry_t head;
  logic             empty;
  logic             full;
  logic             pop;

  assign desc_stall = full;
  assign accept     = desc_valid && !full;

  sgvc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .desc      (desc),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .entry     (entry)
  );

  sgvc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  sgvc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// File: sv/sgvc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgvc_front: descriptor classifier and job state
// Merges or opens vectors, clips the byte total, tracks flags and builds
// one queue entry per request that yields results.
// ----------------------------------------------------------------------------
module sgvc_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  sgvc_pkg::desc_t                      desc,
  input  logic                                 cfg_we,
  input  logic [sgvc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgvc_pkg::CFG_W-1:0]           cfg_data,
  output logic                                 push,
  output sgvc_pkg::entry_t                     entry
);

  logic [sgvc_pkg::LEN_W-1:0]  byte_limit;
  logic [sgvc_pkg::VCNT_W-1:0] max_vectors;

  logic                        active, active_next;
  logic                        stopped, stopped_next;
  logic                        open_valid, open_valid_next;
  logic [sgvc_pkg::ADDR_W-1:0] open_base, open_base_next;
  logic [sgvc_pkg::LEN_W-1:0]  open_len, open_len_next;
  logic [sgvc_pkg::ADDR_W:0]   exp_next, exp_next_next;
  logic [sgvc_pkg::VCNT_W-1:0] vec_cnt, vec_cnt_next;
  logic [sgvc_pkg::LEN_W-1:0]  total, total_next;
  logic                        sync_f, sync_f_next;
  logic                        last_f, last_f_next;
  logic                        limit_f, limit_f_next;
  logic                        full_f, full_f_next;
  logic [sgvc_pkg::LEN_W-1:0]  passed, passed_next;

  logic [sgvc_pkg::VCNT_W-1:0] vmax;
  logic [sgvc_pkg::LEN_W:0]    tot_sum;
  logic                        over;
  logic [sgvc_pkg::LEN_W-1:0]  clen;
  logic [sgvc_pkg::ADDR_W:0]   end_sum;
  logic                        new_vec;
  logic                        pass;
  logic [sgvc_pkg::VCNT_W-1:0] idx_tmp;

  assign vmax = (max_vectors > sgvc_pkg::VEC_HARD_MAX) ? sgvc_pkg::VEC_HARD_MAX : max_vectors;

  always_comb begin
    active_next     = active;
    stopped_next    = stopped;
    open_valid_next = open_valid;
    open_base_next  = open_base;
    open_len_next   = open_len;
    exp_next_next   = exp_next;
    vec_cnt_next    = vec_cnt;
    total_next      = total;
    sync_f_next     = sync_f;
    last_f_next     = last_f;
    limit_f_next    = limit_f;
    full_f_next     = full_f;
    passed_next     = passed;
    tot_sum         = '0;
    over            = 1'b0;
    clen            = '0;
    end_sum         = '0;
    new_vec         = 1'b0;
    pass            = 1'b0;
    idx_tmp         = '0;
    entry           = '0;
    if (accept) begin
      if (desc.chain_start) begin
        active_next     = 1'b1;
        stopped_next    = 1'b0;
        open_valid_next = 1'b0;
        open_base_next  = '0;
        open_len_next   = '0;
        exp_next_next   = '0;
        vec_cnt_next    = '0;
        total_next      = (desc.start_bytes > byte_limit) ? byte_limit : desc.start_bytes;
        sync_f_next     = 1'b0;
        last_f_next     = 1'b0;
        limit_f_next    = 1'b0;
        full_f_next     = 1'b0;
        passed_next     = '0;
      end
      if (active_next) begin
        if (!stopped_next) begin
          pass = 1'b1;
          if (total_next >= byte_limit || desc.buf_kind == sgvc_pkg::KIND_FILE) begin
            stopped_next = 1'b1;
            pass = 1'b0;
          end else if (desc.buf_kind == sgvc_pkg::KIND_MEM) begin
            if (desc.buf_len != '0) begin
              tot_sum = {1'b0, total_next} + {1'b0, desc.buf_len};
              over = tot_sum > {1'b0, byte_limit};
              clen = over ? (byte_limit - total_next) : desc.buf_len;
              if (over) begin
                limit_f_next = 1'b1;
              end
              new_vec = !open_valid_next || exp_next_next[sgvc_pkg::ADDR_W] ||
                        (desc.buf_addr != exp_next_next[sgvc_pkg::ADDR_W-1:0]);
              if (new_vec) begin
                if (vec_cnt_next >= vmax) begin
                  full_f_next  = 1'b1;
                  stopped_next = 1'b1;
                  pass = 1'b0;
                end else begin
                  if (open_valid_next) begin
                    idx_tmp       = vec_cnt_next - sgvc_pkg::VCNT_W'(1);
                    entry.has_a   = 1'b1;
                    entry.a.index = idx_tmp[sgvc_pkg::VIDX_W-1:0];
                    entry.a.base  = open_base_next;
                    entry.a.len   = open_len_next;
                  end
                  open_valid_next = 1'b1;
                  open_base_next  = desc.buf_addr;
                  open_len_next   = clen;
                  vec_cnt_next    = vec_cnt_next + sgvc_pkg::VCNT_W'(1);
                end
              end else begin
                open_len_next = open_len_next + clen;
              end
              if (pass) begin
                total_next    = over ? byte_limit : tot_sum[sgvc_pkg::LEN_W-1:0];
                end_sum       = {1'b0, desc.buf_addr} +
                                {{(sgvc_pkg::ADDR_W + 1 - sgvc_pkg::LEN_W){1'b0}}, clen};
                exp_next_next = end_sum;
              end
            end
          end else begin
            sync_f_next = 1'b1;
            if (desc.last_mark) begin
              last_f_next = 1'b1;
            end
          end
          if (pass && passed_next != sgvc_pkg::PASS_MAX) begin
            passed_next = passed_next + sgvc_pkg::LEN_W'(1);
          end
        end
        if (desc.chain_end) begin
          if (open_valid_next) begin
            idx_tmp       = vec_cnt_next - sgvc_pkg::VCNT_W'(1);
            entry.has_b   = 1'b1;
            entry.b.index = idx_tmp[sgvc_pkg::VIDX_W-1:0];
            entry.b.base  = open_base_next;
            entry.b.len   = open_len_next;
          end
          entry.has_s   = 1'b1;
          entry.s.count = vec_cnt_next;
          entry.s.total = total_next;
          entry.s.sync  = sync_f_next;
          entry.s.last  = last_f_next;
          entry.s.limit = limit_f_next;
          entry.s.full  = full_f_next;
          entry.s.taken = passed_next;
          active_next     = 1'b0;
          stopped_next    = 1'b0;
          open_valid_next = 1'b0;
          open_base_next  = '0;
          open_len_next   = '0;
          exp_next_next   = '0;
          vec_cnt_next    = '0;
          total_next      = '0;
          sync_f_next     = 1'b0;
          last_f_next     = 1'b0;
          limit_f_next    = 1'b0;
          full_f_next     = 1'b0;
          passed_next     = '0;
        end
      end
    end
  end

  assign push = entry.has_a | entry.has_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit  <= sgvc_pkg::BYTE_LIMIT_RST;
      max_vectors <= sgvc_pkg::VEC_HARD_MAX;
      active      <= 1'b0;
      stopped     <= 1'b0;
      open_valid  <= 1'b0;
      open_base   <= '0;
      open_len    <= '0;
      exp_next    <= '0;
      vec_cnt     <= '0;
      total       <= '0;
      sync_f      <= 1'b0;
      last_f      <= 1'b0;
      limit_f     <= 1'b0;
      full_f      <= 1'b0;
      passed      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sgvc_pkg::REG_BYTE_LIMIT: begin
            byte_limit <= cfg_data[sgvc_pkg::LEN_W-1:0];
          end
          sgvc_pkg::REG_MAX_VECTORS: begin
            max_vectors <= cfg_data[sgvc_pkg::VCNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      active     <= active_next;
      stopped    <= stopped_next;
      open_valid <= open_valid_next;
      open_base  <= open_base_next;
      open_len   <= open_len_next;
      exp_next   <= exp_next_next;
      vec_cnt    <= vec_cnt_next;
      total      <= total_next;
      sync_f     <= sync_f_next;
      last_f     <= last_f_next;
      limit_f    <= limit_f_next;
      full_f     <= full_f_next;
      passed     <= passed_next;
    end
  end

endmodule

// File: sv/sgvc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgvc_queue: entry queue between classifier and emitter
// Small register FIFO; the head is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module sgvc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sgvc_pkg::entry_t push_data,
  input  logic             pop,
  output sgvc_pkg::entry_t head,
  output logic             empty,
  output logic             full
);

  sgvc_pkg::entry_t mem [sgvc_pkg::QDEPTH];
  logic [sgvc_pkg::QPTR_W-1:0] wr_ptr;
  logic [sgvc_pkg::QPTR_W-1:0] rd_ptr;
  logic [sgvc_pkg::QCNT_W-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  assign empty   = (count == '0);
  assign full    = (count == sgvc_pkg::QCNT_W'(sgvc_pkg::QDEPTH));
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + sgvc_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + sgvc_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + sgvc_pkg::QCNT_W'(1);
        2'b01:   count <= count - sgvc_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/sgvc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgvc_back: result emitter
// Walks each queue entry and sends its vectors and summary, one result per
// cycle while res_stall is low, through an output register.
// ----------------------------------------------------------------------------
module sgvc_back (
  input  logic             clk,
  input  logic             rst,
  input  sgvc_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output sgvc_pkg::res_t   res
);

  logic           done_a;
  logic           done_b;
  logic           sel_a;
  logic           sel_b;
  logic           last;
  logic           load;
  sgvc_pkg::res_t item;

  assign sel_a = head.has_a && !done_a;
  assign sel_b = !sel_a && head.has_b && !done_b;
  assign last  = sel_a ? !(head.has_b || head.has_s) : (sel_b ? !head.has_s : 1'b1);
  assign load  = !empty && (!res_valid || !res_stall);
  assign pop   = load && last;

  always_comb begin
    item = '0;
    if (sel_a) begin
      item.item_kind = sgvc_pkg::ITEM_VEC;
      item.vec_index = head.a.index;
      item.vec_base  = head.a.base;
      item.vec_len   = head.a.len;
    end else if (sel_b) begin
      item.item_kind = sgvc_pkg::ITEM_VEC;
      item.vec_index = head.b.index;
      item.vec_base  = head.b.base;
      item.vec_len   = head.b.len;
    end else begin
      item.item_kind    = sgvc_pkg::ITEM_SUM;
      item.vector_count = head.s.count;
      item.total_bytes  = head.s.total;
      item.saw_sync     = head.s.sync;
      item.saw_last     = head.s.last;
      item.limit_hit    = head.s.limit;
      item.vectors_full = head.s.full;
      item.taken_count  = head.s.taken;
    end
    item.run_last = last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      done_a    <= 1'b0;
      done_b    <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        if (last) begin
          done_a <= 1'b0;
          done_b <= 1'b0;
        end else begin
          done_a <= done_a | sel_a;
          done_b <= done_b | sel_b;
        end
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
